>>> rtl/framed_serial_sniffer_with_reply_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef FRAMED_SERIAL_SNIFFER_WITH_REPLY_TOP_DEFINES_SVH
`define FRAMED_SERIAL_SNIFFER_WITH_REPLY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/fss_pkg.sv
package fss_pkg;

  // Frame and reply geometry.
  localparam int PACKET_BYTES = 5;
  localparam int REPLY_BITS   = 16;
  localparam int OUT_BYTES    = 5;
  localparam int BYTE_W       = 8;
  localparam int CODE_W       = 16;
  localparam int COUNT_W      = 16;
  localparam int BIT_IW       = 3;
  localparam int BYTE_AW      = $clog2(PACKET_BYTES);
  localparam int BYTE_CW      = $clog2(PACKET_BYTES + 1);
  localparam int REPLY_IW     = (REPLY_BITS > 1) ? $clog2(REPLY_BITS) : 1;

  // Configuration port geometry.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Line event codes.
  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_CLOCK  = 1'b1;

  // Register indexes.
  typedef enum logic [1:0] {
    REG_BUTTON_CODE         = 2'd0,
    REG_REPLY_ENABLE        = 2'd1,
    REG_GET_BUTTONS_COMMAND = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] button_code;
    logic              reply_enable;
    logic [BYTE_W-1:0] get_buttons_command;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    button_code:         '0,
    reply_enable:        1'b1,
    get_buttons_command: 8'h10
  };

endpackage

>>> rtl/fss_chan_if.sv
// Line event channel: one select or clock change per word.
interface fss_event_if;
  logic valid;
  logic ready;
  logic req_type;
  logic line_level;
  logic rx_bit;

  modport source (output valid, req_type, line_level, rx_bit, input ready);
  modport sink (input valid, req_type, line_level, rx_bit, output ready);
endinterface

// Result channel: one word per line event.
interface fss_result_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_valid;
  logic                          drive_level;
  logic                          packet_done;
  logic                          packet_short;
  logic [fss_pkg::BYTE_W-1:0]    packet_byte_0;
  logic [fss_pkg::BYTE_W-1:0]    packet_byte_1;
  logic [fss_pkg::BYTE_W-1:0]    packet_byte_2;
  logic [fss_pkg::BYTE_W-1:0]    packet_byte_3;
  logic [fss_pkg::BYTE_W-1:0]    packet_byte_4;
  logic [fss_pkg::COUNT_W-1:0]   good_total;
  logic [fss_pkg::COUNT_W-1:0]   bad_total;

  modport source (
    output valid, drive_valid, drive_level, packet_done, packet_short,
           packet_byte_0, packet_byte_1, packet_byte_2, packet_byte_3, packet_byte_4,
           good_total, bad_total,
    input  ready
  );
  modport sink (
    input  valid, drive_valid, drive_level, packet_done, packet_short,
           packet_byte_0, packet_byte_1, packet_byte_2, packet_byte_3, packet_byte_4,
           good_total, bad_total,
    output ready
  );
endinterface

>>> rtl/fss_cfg.sv
module fss_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fss_pkg::ADDR_W-1:0]   paddr,
  input  logic [fss_pkg::DATA_W-1:0]   pwdata,
  output logic [fss_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output fss_pkg::cfg_t                cfg
);

  fss_pkg::cfg_t     cfg_next;
  fss_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = fss_pkg::reg_idx_t'(paddr[fss_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      case (reg_idx)
        fss_pkg::REG_BUTTON_CODE: begin
          cfg_next.button_code = pwdata[fss_pkg::CODE_W-1:0];
        end
        fss_pkg::REG_REPLY_ENABLE: begin
          cfg_next.reply_enable = pwdata[0];
        end
        fss_pkg::REG_GET_BUTTONS_COMMAND: begin
          cfg_next.get_buttons_command = pwdata[fss_pkg::BYTE_W-1:0];
        end
        default: begin
          cfg_next = cfg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= fss_pkg::CFG_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

  // Register read mux.
  always_comb begin
    case (reg_idx)
      fss_pkg::REG_BUTTON_CODE: begin
        prdata = fss_pkg::DATA_W'(cfg.button_code);
      end
      fss_pkg::REG_REPLY_ENABLE: begin
        prdata = fss_pkg::DATA_W'(cfg.reply_enable);
      end
      fss_pkg::REG_GET_BUTTONS_COMMAND: begin
        prdata = fss_pkg::DATA_W'(cfg.get_buttons_command);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

>>> rtl/fss_core.sv
module fss_core (
  input  logic               clk,
  input  logic               rst,
  input  fss_pkg::cfg_t      cfg,
  fss_event_if.sink          line_event,
  fss_result_if.source       result
);

  // Frame tracking state.
  logic                          frame_open, frame_open_next;
  logic [fss_pkg::BYTE_W-1:0]    shift_byte, shift_byte_next;
  logic [fss_pkg::BIT_IW-1:0]    bit_index, bit_index_next;
  logic [fss_pkg::BYTE_CW-1:0]   byte_index, byte_index_next;
  logic [fss_pkg::BYTE_W-1:0]    capture_bytes [fss_pkg::PACKET_BYTES];
  logic [fss_pkg::BYTE_W-1:0]    capture_bytes_next [fss_pkg::PACKET_BYTES];
  logic [fss_pkg::BYTE_W-1:0]    ready_bytes [fss_pkg::PACKET_BYTES];
  logic [fss_pkg::BYTE_W-1:0]    ready_bytes_next [fss_pkg::PACKET_BYTES];

  // Reply state.
  logic                          replying, replying_next;
  logic [fss_pkg::REPLY_IW-1:0]  reply_index, reply_index_next;
  logic                          reply_line, reply_line_next;

  // Counters.
  logic [fss_pkg::COUNT_W-1:0]   good_count, good_count_next;
  logic [fss_pkg::COUNT_W-1:0]   bad_count, bad_count_next;

  // Output register flags.
  logic                          out_valid, out_valid_next;
  logic                          drive_valid, drive_valid_next;
  logic                          packet_done, packet_done_next;
  logic                          packet_short, packet_short_next;

  logic                          accept;
  logic                          good_close;
  logic [fss_pkg::BYTE_W-1:0]    shifted;
  logic [fss_pkg::BYTE_W-1:0]    out_bytes [fss_pkg::OUT_BYTES];

  // A new word enters whenever the output slot is empty or being emptied.
  assign line_event.ready = !out_valid || result.ready;
  assign accept           = line_event.valid && line_event.ready;

  assign shifted    = {line_event.rx_bit, shift_byte[fss_pkg::BYTE_W-1:1]};
  assign good_close = (byte_index >= fss_pkg::BYTE_CW'(fss_pkg::PACKET_BYTES)) ||
                      ((byte_index == fss_pkg::BYTE_CW'(fss_pkg::PACKET_BYTES - 1)) &&
                       (bit_index != '0));

  // Next state for one line event.
  always_comb begin
    frame_open_next    = frame_open;
    shift_byte_next    = shift_byte;
    bit_index_next     = bit_index;
    byte_index_next    = byte_index;
    capture_bytes_next = capture_bytes;
    ready_bytes_next   = ready_bytes;
    replying_next      = replying;
    reply_index_next   = reply_index;
    reply_line_next    = reply_line;
    good_count_next    = good_count;
    bad_count_next     = bad_count;
    drive_valid_next   = drive_valid;
    packet_done_next   = packet_done;
    packet_short_next  = packet_short;

    if (accept) begin
      drive_valid_next  = 1'b0;
      packet_done_next  = 1'b0;
      packet_short_next = 1'b0;
      if (line_event.req_type == fss_pkg::REQ_SELECT) begin
        if (line_event.line_level) begin
          // Select rises: close and classify an open frame.
          if (frame_open) begin
            frame_open_next = 1'b0;
            replying_next   = 1'b0;
            if (good_close) begin
              ready_bytes_next = capture_bytes;
              good_count_next  = good_count + 1'b1;
              packet_done_next = 1'b1;
            end else if (byte_index != '0) begin
              bad_count_next    = bad_count + 1'b1;
              packet_short_next = 1'b1;
            end
          end
        end else begin
          // Select falls: start a fresh frame.
          frame_open_next = 1'b1;
          bit_index_next  = '0;
          byte_index_next = '0;
          shift_byte_next = '0;
          replying_next   = 1'b0;
          for (int i = 0; i < fss_pkg::PACKET_BYTES; i++) begin
            capture_bytes_next[i] = '0;
          end
        end
      end else if (frame_open) begin
        if (line_event.line_level) begin
          // Clock rises: shift in one bit, LSB first.
          shift_byte_next = shifted;
          bit_index_next  = bit_index + 1'b1;
          if (bit_index == '1) begin
            if (byte_index < fss_pkg::BYTE_CW'(fss_pkg::PACKET_BYTES)) begin
              capture_bytes_next[byte_index[fss_pkg::BYTE_AW-1:0]] = shifted;
              byte_index_next = byte_index + 1'b1;
            end
            if (shifted == cfg.get_buttons_command) begin
              replying_next    = 1'b1;
              reply_index_next = '0;
            end
            shift_byte_next = '0;
          end
        end else if (replying && cfg.reply_enable) begin
          // Clock falls: drive the next reply bit.
          reply_line_next  = cfg.button_code[reply_index];
          drive_valid_next = 1'b1;
          if (reply_index == fss_pkg::REPLY_IW'(fss_pkg::REPLY_BITS - 1)) begin
            reply_index_next = '0;
            replying_next    = 1'b0;
          end else begin
            reply_index_next = reply_index + 1'b1;
          end
        end
      end
    end
  end

  // The output slot fills on accept and empties when taken.
  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open   <= 1'b0;
      shift_byte   <= '0;
      bit_index    <= '0;
      byte_index   <= '0;
      replying     <= 1'b0;
      reply_index  <= '0;
      reply_line   <= 1'b0;
      good_count   <= '0;
      bad_count    <= '0;
      out_valid    <= 1'b0;
      drive_valid  <= 1'b0;
      packet_done  <= 1'b0;
      packet_short <= 1'b0;
      for (int i = 0; i < fss_pkg::PACKET_BYTES; i++) begin
        capture_bytes[i] <= '0;
        ready_bytes[i]   <= '0;
      end
    end else begin
      frame_open    <= frame_open_next;
      shift_byte    <= shift_byte_next;
      bit_index     <= bit_index_next;
      byte_index    <= byte_index_next;
      replying      <= replying_next;
      reply_index   <= reply_index_next;
      reply_line    <= reply_line_next;
      good_count    <= good_count_next;
      bad_count     <= bad_count_next;
      out_valid     <= out_valid_next;
      drive_valid   <= drive_valid_next;
      packet_done   <= packet_done_next;
      packet_short  <= packet_short_next;
      capture_bytes <= capture_bytes_next;
      ready_bytes   <= ready_bytes_next;
    end
  end

  // Bytes past the packet length read as zero.
  for (genvar j = 0; j < fss_pkg::OUT_BYTES; j++) begin : g_out_bytes
    if (j < fss_pkg::PACKET_BYTES) begin : g_used
      assign out_bytes[j] = ready_bytes[j];
    end else begin : g_unused
      assign out_bytes[j] = '0;
    end
  end

  // The state registers hold while the word waits, so they feed the result.
  assign result.valid         = out_valid;
  assign result.drive_valid   = drive_valid;
  assign result.drive_level   = reply_line;
  assign result.packet_done   = packet_done;
  assign result.packet_short  = packet_short;
  assign result.packet_byte_0 = out_bytes[0];
  assign result.packet_byte_1 = out_bytes[1];
  assign result.packet_byte_2 = out_bytes[2];
  assign result.packet_byte_3 = out_bytes[3];
  assign result.packet_byte_4 = out_bytes[4];
  assign result.good_total    = good_count;
  assign result.bad_total     = bad_count;

endmodule

>>> rtl/framed_serial_sniffer_with_reply_top.sv
// A result word is valid in the cycle after its line event is accepted.
// Throughput: one line event per cycle while results are taken; the single
// output register frees its slot in the same cycle its word is taken.
// Reset: synchronous, active high; clears the frame, reply and counter state,
// the last packet bytes and the output slot, and loads the register defaults.
module framed_serial_sniffer_with_reply_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fss_pkg::ADDR_W-1:0]   paddr,
  input  logic [fss_pkg::DATA_W-1:0]   pwdata,
  output logic [fss_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  fss_event_if.sink                    line_event,
  fss_result_if.source                 result
);

  fss_pkg::cfg_t cfg;

  // Configuration registers.
  fss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Event processing and result register.
  fss_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .line_event (line_event),
    .result     (result)
  );

endmodule

>>> rtl/fss_checker.sv
`include "framed_serial_sniffer_with_reply_top_defines.svh"

module fss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          drive_valid,
  input logic                          packet_done,
  input logic                          packet_short,
  input logic [fss_pkg::COUNT_W-1:0]   good_total,
  input logic [fss_pkg::COUNT_W-1:0]   bad_total
);

  // Every accepted word yields a result word in the next cycle.
  `FSS_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

  // An empty output slot never stalls the input side.
  `FSS_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // A frame close drives no reply bit and is never both good and short.
  `FSS_ASSERT_SAME(a_close_exclusive, out_valid && (packet_done || packet_short),
                   !drive_valid && !(packet_done && packet_short))

  // A stalled result word keeps its counters.
  `FSS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                   out_valid && $stable(good_total) && $stable(bad_total))

endmodule

bind framed_serial_sniffer_with_reply_top fss_checker u_fss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (line_event.valid),
  .in_ready     (line_event.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .drive_valid  (result.drive_valid),
  .packet_done  (result.packet_done),
  .packet_short (result.packet_short),
  .good_total   (result.good_total),
  .bad_total    (result.bad_total)
);
